// ----- rtl/core/assert_macros.svh -----
// Assertion helpers included by media_rate_meter_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication: cons holds whenever ante holds.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication: cons holds in the cycle after ante.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/mrm_pkg.sv -----
`default_nettype none

package mrm_pkg;

  localparam int TIME_W = 63;
  localparam int CNT_W  = 32;
  localparam int FPS_W  = 16;
  localparam int KBPS_W = 32;

  localparam int NUM_CNT  = 6;
  localparam int NUM_FPS  = 4;
  localparam int NUM_KBPS = 2;

  localparam int SCALE_W = 20;
  localparam int PROD_W  = CNT_W + SCALE_W;
  localparam int NUM_W   = 64;

  localparam logic [SCALE_W-1:0] FPS_SCALE  = 20'd1000000;
  localparam logic [SCALE_W-1:0] KBPS_SCALE = 20'd8000;

  localparam logic [31:0] WINDOW_RESET = 32'd1000000;

  // Byte address bits of the configuration port; bit 2 picks the register.
  localparam int ADDR_W = 3;
  localparam logic REG_WINDOW = 1'b0;

endpackage

`default_nettype wire

// ----- rtl/core/mrm_if.sv -----
`default_nettype none

interface mrm_in_if;
  import mrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_time_us;
  logic              link_up;
  logic              in_call;
  logic [CNT_W-1:0]  sent_video_frames;
  logic [CNT_W-1:0]  recv_video_frames;
  logic [CNT_W-1:0]  sent_audio_frames;
  logic [CNT_W-1:0]  recv_audio_frames;
  logic [CNT_W-1:0]  sent_video_bytes;
  logic [CNT_W-1:0]  recv_video_bytes;

  modport source (
    output valid, now_time_us, link_up, in_call, sent_video_frames, recv_video_frames,
           sent_audio_frames, recv_audio_frames, sent_video_bytes, recv_video_bytes,
    input  ready
  );

  modport sink (
    input  valid, now_time_us, link_up, in_call, sent_video_frames, recv_video_frames,
           sent_audio_frames, recv_audio_frames, sent_video_bytes, recv_video_bytes,
    output ready
  );
endinterface

interface mrm_out_if;
  import mrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [FPS_W-1:0]  sent_video_fps;
  logic [FPS_W-1:0]  recv_video_fps;
  logic [FPS_W-1:0]  sent_audio_fps;
  logic [FPS_W-1:0]  recv_audio_fps;
  logic [KBPS_W-1:0] sent_video_kbps;
  logic [KBPS_W-1:0] recv_video_kbps;

  modport source (
    output valid, sent_video_fps, recv_video_fps, sent_audio_fps, recv_audio_fps,
           sent_video_kbps, recv_video_kbps,
    input  ready
  );

  modport sink (
    input  valid, sent_video_fps, recv_video_fps, sent_audio_fps, recv_audio_fps,
           sent_video_kbps, recv_video_kbps,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/media_rate_meter_unit.sv -----
// Channel   Dir  Handshake       Word
// --------  ---  --------------  ---------------------------------------------
// in_ch     in   valid / ready   timestamp, link/call flags, six counters
// out_ch    out  valid / ready   four fps rates, two kbps rates
// APB       in   psel / penable  window_us at byte address 0
//
// A word that clears (inactive, no baseline, time not advanced, counter
// dropped) or is quiet below the window passes through accept, evaluate,
// decide and load result before out_ch.valid rises. A word that
// refreshes the rates takes the same steps and, between decide and load,
// works six rates, each one multiply, one add, 64 steps of the shared
// restoring divider and one store.
// in_ch.ready is high only while the sequencer is idle; a finished result
// waits in the output register, and the next word is taken meanwhile.
// Reset (rst, synchronous) clears the baseline and held rates and restores
// the window to one second.
`include "assert_macros.svh"
`default_nettype none

module media_rate_meter_unit (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire [mrm_pkg::ADDR_W-1:0] paddr,
  input  wire [31:0]                pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  mrm_in_if.sink                    in_ch,
  mrm_out_if.source                 out_ch
);
  import mrm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DECIDE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_STORE,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration
  logic [31:0] window_us;

  // Captured word
  logic [TIME_W-1:0] now_time;
  logic              active;
  logic [CNT_W-1:0]  cnt [NUM_CNT];

  // Long-lived state
  logic [CNT_W-1:0]  base_counts [NUM_CNT];
  logic [TIME_W-1:0] base_time;
  logic [FPS_W-1:0]  held_fps [NUM_FPS];
  logic [KBPS_W-1:0] held_kbps [NUM_KBPS];

  // Evaluation results
  logic [CNT_W-1:0]  delta [NUM_CNT];
  logic              went_down;
  logic              any_delta;
  logic              time_ok;
  logic              no_base;
  logic              full;
  logic [TIME_W-1:0] elapsed;

  // Shared divider datapath
  logic [2:0]        k;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  quo;
  logic [TIME_W-1:0] rem;
  logic [5:0]        step;

  logic              in_acc;
  logic              cfg_wr;
  logic              clear_cond;
  logic              full_now;
  logic [NUM_W-1:0]  rem_sh;
  logic [NUM_W-1:0]  div_ext;
  logic              div_ge;
  logic [NUM_W-1:0]  rem_sub;
  logic [SCALE_W-1:0] scale;
  logic [CNT_W-1:0]  in_cnt [NUM_CNT];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW);
  assign prdata = (paddr[2] == REG_WINDOW) ? window_us : 32'd0;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign in_cnt[0] = in_ch.sent_video_frames;
  assign in_cnt[1] = in_ch.recv_video_frames;
  assign in_cnt[2] = in_ch.sent_audio_frames;
  assign in_cnt[3] = in_ch.recv_audio_frames;
  assign in_cnt[4] = in_ch.sent_video_bytes;
  assign in_cnt[5] = in_ch.recv_video_bytes;

  // Any of these forces a clear of the held rates and a fresh baseline.
  assign clear_cond = !active || no_base || !time_ok || went_down;
  assign full_now   = elapsed >= {{(TIME_W-32){1'b0}}, window_us};

  // First four rates are frames per second, last two kilobits per second.
  assign scale = (k < 3'(NUM_FPS)) ? FPS_SCALE : KBPS_SCALE;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign div_ext = {1'b0, elapsed};
  assign div_ge  = rem_sh >= div_ext;
  assign rem_sub = rem_sh - div_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window_us   <= WINDOW_RESET;
      base_time   <= '0;
      out_ch.valid <= 1'b0;
      k           <= '0;
      step        <= '0;
      for (int i = 0; i < NUM_CNT; i++) begin
        base_counts[i] <= '0;
      end
      for (int i = 0; i < NUM_FPS; i++) begin
        held_fps[i] <= '0;
      end
      for (int i = 0; i < NUM_KBPS; i++) begin
        held_kbps[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        window_us <= pwdata;
      end

      // Drop the result once the sink has taken it; the finish state
      // reloads the register itself.
      if (out_ch.valid && out_ch.ready && state != ST_FINISH) begin
        out_ch.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            now_time <= in_ch.now_time_us;
            active   <= in_ch.link_up && in_ch.in_call;
            for (int i = 0; i < NUM_CNT; i++) begin
              cnt[i] <= in_cnt[i];
            end
            state <= ST_EVAL;
          end
        end

        ST_EVAL: begin
          // Deltas and flags against the baseline, all lanes side by side.
          went_down <= 1'b0;
          any_delta <= 1'b0;
          for (int i = 0; i < NUM_CNT; i++) begin
            delta[i] <= cnt[i] - base_counts[i];
            if (cnt[i] < base_counts[i]) begin
              went_down <= 1'b1;
            end
            if (cnt[i] != base_counts[i]) begin
              any_delta <= 1'b1;
            end
          end
          elapsed <= now_time - base_time;
          time_ok <= now_time > base_time;
          no_base <= (base_time == '0);
          state   <= ST_DECIDE;
        end

        ST_DECIDE: begin
          full <= full_now;
          if (clear_cond) begin
            for (int i = 0; i < NUM_FPS; i++) begin
              held_fps[i] <= '0;
            end
            for (int i = 0; i < NUM_KBPS; i++) begin
              held_kbps[i] <= '0;
            end
            for (int i = 0; i < NUM_CNT; i++) begin
              base_counts[i] <= cnt[i];
            end
            base_time <= now_time;
            state     <= ST_FINISH;
          end else if (full_now || any_delta) begin
            k     <= '0;
            state <= ST_MUL;
          end else begin
            // Quiet below the window: hold rates and baseline.
            state <= ST_FINISH;
          end
        end

        ST_MUL: begin
          prod  <= delta[k] * scale;
          state <= ST_ADD;
        end

        ST_ADD: begin
          // Add half the divisor for round-to-nearest.
          quo   <= {{(NUM_W-PROD_W){1'b0}}, prod} + {2'b00, elapsed[TIME_W-1:1]};
          rem   <= '0;
          step  <= '0;
          state <= ST_DIV;
        end

        ST_DIV: begin
          rem  <= div_ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
          quo  <= {quo[NUM_W-2:0], div_ge};
          step <= step + 6'd1;
          if (step == 6'(NUM_W-1)) begin
            state <= ST_STORE;
          end
        end

        ST_STORE: begin
          // Saturate the quotient into the held rate of this lane.
          if (k < 3'(NUM_FPS)) begin
            held_fps[k[1:0]] <= (|quo[NUM_W-1:FPS_W]) ? '1 : quo[FPS_W-1:0];
          end else begin
            held_kbps[k[0]] <= (|quo[NUM_W-1:KBPS_W]) ? '1 : quo[KBPS_W-1:0];
          end
          if (k == 3'(NUM_CNT-1)) begin
            if (full) begin
              for (int i = 0; i < NUM_CNT; i++) begin
                base_counts[i] <= cnt[i];
              end
              base_time <= now_time;
            end
            state <= ST_FINISH;
          end else begin
            k     <= k + 3'd1;
            state <= ST_MUL;
          end
        end

        ST_FINISH: begin
          // Hold until the output register is free, then load it.
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid           <= 1'b1;
            out_ch.sent_video_fps  <= held_fps[0];
            out_ch.recv_video_fps  <= held_fps[1];
            out_ch.sent_audio_fps  <= held_fps[2];
            out_ch.recv_audio_fps  <= held_fps[3];
            out_ch.sent_video_kbps <= held_kbps[0];
            out_ch.recv_video_kbps <= held_kbps[1];
            state                  <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_busy, clk, rst, in_acc, !in_ch.ready && state == ST_EVAL)
  `ASSERT_IMPLY(a_rem_below_div, clk, rst, state == ST_DIV, rem < elapsed)
  `ASSERT_IMPLY(a_lane_range, clk, rst, state == ST_STORE || state == ST_MUL, k < 3'(NUM_CNT))
  `ASSERT_NEXT(a_clear_zero, clk, rst, state == ST_DECIDE && clear_cond, held_fps[0] == '0 && held_kbps[1] == '0 && base_time == $past(now_time))

endmodule

`default_nettype wire
